FILE: design/astar_pkg.sv
// ----------------------------------------------------------------------------
// A* path search package
// Shared widths, command and status codes, and small arithmetic helpers.
// ----------------------------------------------------------------------------
package astar_pkg;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned NODE_W  = 6;
    localparam int unsigned COORD_W = 24;
    localparam int unsigned LEN_W   = 24;
    localparam int unsigned COST_W  = 32;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned DEG_W   = 4;
    localparam int unsigned KEY_W   = COST_W + NODE_W;
    localparam int unsigned WP_W    = 3 * COORD_W;

    // square root of a sum of three 48-bit squares
    localparam int unsigned MAG_W   = COORD_W;
    localparam int unsigned PROD_W  = 2 * MAG_W;
    localparam int unsigned SQ_W    = PROD_W + 3;
    localparam int unsigned SQ_ITER = PROD_W / 2 + 1;
    localparam int unsigned SQC_W   = $clog2(SQ_ITER);

    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_EDGE = 2'd1,
        CMD_FIND = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_PATH     = 3'd0,
        ST_LOADED   = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOPATH   = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // saturating cost add
    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_MAX : s[COST_W-1:0];
    endfunction

    // magnitude of the difference of two signed coordinates
    function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] n;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        n = -d;
        return d[COORD_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
    endfunction

endpackage

FILE: design/astar_waypoint_path_search_unit.sv
// ----------------------------------------------------------------------------
// A* waypoint path search unit
// Waypoint table, edge lists and an A* search with a binary open heap.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; in_stall stays high until its last
// result has been handed to the output register, or until a load or edge
// command with an out-of-range node is dropped without a result. A search
// sets up, then per heap pop sifts the tail entry down level by level, per
// edge reads the neighbour's best cost, and per relaxed edge runs 4 multiply
// steps and a 25-step square root that resolves one root bit a cycle, then
// sifts up level by level; at the end it walks the path back, then emits it.
// The table memories have a registered read, and the square root is
// bit-serial. All tables are memories; the edge degree and the per-search
// "cost known" marks are held in valid flops, so no clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module astar_waypoint_path_search_unit
    import astar_pkg::*;
#(
    parameter int unsigned NODES      = 64,
    parameter int unsigned MAX_DEGREE = 8,
    parameter int unsigned HEAP_DEPTH = 512
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [NODE_W-1:0]   node,
    input  logic [NODE_W-1:0]   target,
    input  logic [NODE_W-1:0]   neighbour,
    input  logic [LEN_W-1:0]    edge_length,
    input  logic [COORD_W-1:0]  coord_x,
    input  logic [COORD_W-1:0]  coord_y,
    input  logic [COORD_W-1:0]  coord_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STAT_W-1:0]   status,
    output logic [NODE_W-1:0]   path_node,
    output logic [COST_W-1:0]   path_cost,
    output logic                last
);

    localparam int unsigned NAW  = $clog2(NODES);
    localparam int unsigned NCW  = $clog2(NODES + 1);
    localparam int unsigned NCMP = NODE_W + 1;
    localparam int unsigned EDEP = NODES * MAX_DEGREE;
    localparam int unsigned EAW  = (EDEP > 1) ? $clog2(EDEP) : 1;
    localparam int unsigned HAW  = $clog2(HEAP_DEPTH);
    localparam int unsigned HCW  = $clog2(HEAP_DEPTH + 1);
    localparam int unsigned CIW  = HCW + 1;
    localparam int unsigned EW   = NODE_W + LEN_W;

    typedef enum logic [24:0] {
        S_IDLE  = 25'h0000001,
        S_CMD   = 25'h0000002,
        S_EDGE  = 25'h0000004,
        S_GOAL  = 25'h0000008,
        S_POP   = 25'h0000010,
        S_POPD  = 25'h0000020,
        S_SDRD  = 25'h0000040,
        S_SDCMP = 25'h0000080,
        S_EXP   = 25'h0000100,
        S_EXD   = 25'h0000200,
        S_ECHK  = 25'h0000400,
        S_ETGT  = 25'h0000800,
        S_EBC   = 25'h0001000,
        S_DRD   = 25'h0002000,
        S_DMUL  = 25'h0004000,
        S_SQRT  = 25'h0008000,
        S_PUSH  = 25'h0010000,
        S_UCHK  = 25'h0020000,
        S_UCMP  = 25'h0040000,
        S_WPUT  = 25'h0080000,
        S_WNXT  = 25'h0100000,
        S_ORD   = 25'h0200000,
        S_OND   = 25'h0400000,
        S_OEMIT = 25'h0800000,
        S_EMIT  = 25'h1000000
    } state_t;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic [WP_W-1:0]   wp_mem   [NODES];
    logic [DEG_W-1:0]  deg_mem  [NODES];
    logic [EW-1:0]     edge_mem [EDEP];
    logic [COST_W-1:0] best_mem [NODES];
    logic [NODE_W-1:0] par_mem  [NODES];
    logic [NODE_W-1:0] path_mem [NODES];
    logic [KEY_W-1:0]  heap_mem [HEAP_DEPTH];

    logic              wp_we;
    logic [NAW-1:0]    wp_wa, wp_ra;
    logic [WP_W-1:0]   wp_wd, wp_rd;
    logic              deg_we;
    logic [NAW-1:0]    deg_wa, deg_ra;
    logic [DEG_W-1:0]  deg_wd, deg_rd;
    logic              edge_we;
    logic [EAW-1:0]    edge_wa, edge_ra;
    logic [EW-1:0]     edge_wd, edge_rd;
    logic              best_we;
    logic [NAW-1:0]    best_wa, best_ra;
    logic [COST_W-1:0] best_wd, best_rd;
    logic              par_we;
    logic [NAW-1:0]    par_wa, par_ra;
    logic [NODE_W-1:0] par_wd, par_rd;
    logic              path_we;
    logic [NAW-1:0]    path_wa, path_ra;
    logic [NODE_W-1:0] path_wd, path_rd;
    logic              heap_we;
    logic [HAW-1:0]    heap_wa, heap_ra, heap_rb;
    logic [KEY_W-1:0]  heap_wd, heap_rda, heap_rdb;

    always_ff @(posedge clk)
    begin
        if (wp_we)   wp_mem[wp_wa]     <= wp_wd;
        if (deg_we)  deg_mem[deg_wa]   <= deg_wd;
        if (edge_we) edge_mem[edge_wa] <= edge_wd;
        if (best_we) best_mem[best_wa] <= best_wd;
        if (par_we)  par_mem[par_wa]   <= par_wd;
        if (path_we) path_mem[path_wa] <= path_wd;
        if (heap_we) heap_mem[heap_wa] <= heap_wd;
        wp_rd    <= wp_mem[wp_ra];
        deg_rd   <= deg_mem[deg_ra];
        edge_rd  <= edge_mem[edge_ra];
        best_rd  <= best_mem[best_ra];
        par_rd   <= par_mem[par_ra];
        path_rd  <= path_mem[path_ra];
        heap_rda <= heap_mem[heap_ra];
        heap_rdb <= heap_mem[heap_rb];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [NODE_W-1:0]  nd_reg, nd_next, tg_reg, tg_next, nb_reg, nb_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [WP_W-1:0]    cw_reg, cw_next;
    logic [WP_W-1:0]    goal_reg, goal_next;
    logic [HCW-1:0]     hcnt_reg, hcnt_next;
    logic [CIW-1:0]     idx_reg, idx_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [NODE_W-1:0]  cur_reg, cur_next;
    logic [DEG_W-1:0]   deg_reg, deg_next, e_reg, e_next;
    logic [COST_W-1:0]  bc_reg, bc_next, nc_reg, nc_next;
    logic [NODE_W-1:0]  nx_reg, nx_next;
    logic [MAG_W-1:0]   mag_reg [3];
    logic [MAG_W-1:0]   mag_next [3];
    logic [1:0]         k_reg, k_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [SQ_W-1:0]    acc_reg, acc_next;
    logic [SQ_W-1:0]    sqn_reg, sqn_next, sqr_reg, sqr_next, sqb_reg, sqb_next;
    logic [SQC_W-1:0]   sqc_reg, sqc_next;
    logic [NCW-1:0]     pn_reg, pn_next;
    logic [NCW-1:0]     oi_reg, oi_next;
    logic [NODE_W-1:0]  wc_reg, wc_next;
    logic [NODES-1:0]   known_reg, known_next;
    logic [NODES-1:0]   degv_reg, degv_next;
    logic [STAT_W-1:0]  em_st_reg, em_st_next;
    logic [NODE_W-1:0]  em_nd_reg, em_nd_next;

    logic               ov_reg;
    logic [STAT_W-1:0]  ost_reg;
    logic [NODE_W-1:0]  ond_reg;
    logic [COST_W-1:0]  ocost_reg;
    logic               olast_reg;

    // output staging
    logic               out_free;
    logic               emit;
    logic [STAT_W-1:0]  emit_st;
    logic [NODE_W-1:0]  emit_nd;
    logic [COST_W-1:0]  emit_cost;
    logic               emit_last;

    assign out_free  = !ov_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign status    = ost_reg;
    assign path_node = ond_reg;
    assign path_cost = ocost_reg;
    assign last      = olast_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [DEG_W-1:0]  d_eff;
    logic [CIW-1:0]    ca, cb, hcnt_x, par_i;
    logic              use_b;
    logic [KEY_W-1:0]  child;
    logic [SQ_W-1:0]   sq_t, r_new;
    logic [MAG_W-1:0]  msel;
    logic [COST_W-1:0] nc_calc;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        nd_next    = nd_reg;
        tg_next    = tg_reg;
        nb_next    = nb_reg;
        len_next   = len_reg;
        cw_next    = cw_reg;
        goal_next  = goal_reg;
        hcnt_next  = hcnt_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        cur_next   = cur_reg;
        deg_next   = deg_reg;
        e_next     = e_reg;
        bc_next    = bc_reg;
        nc_next    = nc_reg;
        nx_next    = nx_reg;
        mag_next   = mag_reg;
        k_next     = k_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        sqn_next   = sqn_reg;
        sqr_next   = sqr_reg;
        sqb_next   = sqb_reg;
        sqc_next   = sqc_reg;
        pn_next    = pn_reg;
        oi_next    = oi_reg;
        wc_next    = wc_reg;
        known_next = known_reg;
        degv_next  = degv_reg;
        em_st_next = em_st_reg;
        em_nd_next = em_nd_reg;

        wp_we = 1'b0;  wp_wa = '0;  wp_wd = cw_reg;  wp_ra = '0;
        deg_we = 1'b0; deg_wa = '0; deg_wd = '0;     deg_ra = '0;
        edge_we = 1'b0; edge_wa = '0; edge_wd = {nb_reg, len_reg}; edge_ra = '0;
        best_we = 1'b0; best_wa = '0; best_wd = '0;  best_ra = '0;
        par_we = 1'b0; par_wa = '0; par_wd = cur_reg; par_ra = '0;
        path_we = 1'b0; path_wa = '0; path_wd = wc_reg; path_ra = '0;
        heap_we = 1'b0; heap_wa = '0; heap_wd = key_reg; heap_ra = '0; heap_rb = '0;

        emit      = 1'b0;
        emit_st   = em_st_reg;
        emit_nd   = em_nd_reg;
        emit_cost = '0;
        emit_last = 1'b1;

        d_eff   = degv_reg[NAW'(nd_reg)] ? deg_rd : '0;
        hcnt_x  = CIW'(hcnt_reg);
        ca      = (idx_reg << 1) + CIW'(1);
        cb      = ca + CIW'(1);
        use_b   = (cb < hcnt_x) && (heap_rdb < heap_rda);
        child   = use_b ? heap_rdb : heap_rda;
        par_i   = (idx_reg - CIW'(1)) >> 1;
        sq_t    = sqr_reg + sqb_reg;
        r_new   = (sqn_reg >= sq_t) ? ((sqr_reg >> 1) + sqb_reg) : (sqr_reg >> 1);
        nc_calc = sat_add(bc_reg, COST_W'(edge_rd[LEN_W-1:0]));
        unique case (k_reg)
            2'd0:    msel = mag_reg[0];
            2'd1:    msel = mag_reg[1];
            2'd2:    msel = mag_reg[2];
            default: msel = '0;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    nd_next    = node;
                    tg_next    = target;
                    nb_next    = neighbour;
                    len_next   = edge_length;
                    cw_next    = {coord_x, coord_y, coord_z};
                    state_next = S_CMD;
                end
            end

            S_CMD:
            begin
                unique case (cmd_reg)
                    CMD_LOAD:
                    begin
                        if (NCMP'(nd_reg) >= NCMP'(NODES))
                            state_next = S_IDLE;
                        else
                        begin
                            wp_we  = 1'b1;
                            wp_wa  = NAW'(nd_reg);
                            deg_we = 1'b1;
                            deg_wa = NAW'(nd_reg);
                            degv_next[NAW'(nd_reg)] = 1'b1;
                            em_st_next = ST_LOADED;
                            em_nd_next = nd_reg;
                            state_next = S_EMIT;
                        end
                    end
                    CMD_EDGE:
                    begin
                        if (NCMP'(nd_reg) >= NCMP'(NODES) || NCMP'(nb_reg) >= NCMP'(NODES))
                            state_next = S_IDLE;
                        else
                        begin
                            deg_ra     = NAW'(nd_reg);
                            state_next = S_EDGE;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (NCMP'(nd_reg) >= NCMP'(NODES) || NCMP'(tg_reg) >= NCMP'(NODES))
                        begin
                            em_st_next = ST_NOPATH;
                            em_nd_next = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            known_next = '0;
                            known_next[NAW'(nd_reg)] = 1'b1;
                            best_we = 1'b1;
                            best_wa = NAW'(nd_reg);
                            par_we  = 1'b1;
                            par_wa  = NAW'(nd_reg);
                            par_wd  = nd_reg;
                            heap_we = 1'b1;
                            heap_wa = '0;
                            heap_wd = KEY_W'(nd_reg);
                            hcnt_next  = HCW'(1);
                            wp_ra      = NAW'(tg_reg);
                            state_next = S_GOAL;
                        end
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end

            // append the edge or flag the full list
            S_EDGE:
            begin
                em_nd_next = nd_reg;
                if (32'(d_eff) >= MAX_DEGREE)
                    em_st_next = ST_FULL;
                else
                begin
                    edge_we = 1'b1;
                    edge_wa = EAW'(32'(nd_reg) * MAX_DEGREE + 32'(d_eff));
                    deg_we  = 1'b1;
                    deg_wa  = NAW'(nd_reg);
                    deg_wd  = d_eff + DEG_W'(1);
                    degv_next[NAW'(nd_reg)] = 1'b1;
                    em_st_next = ST_LOADED;
                end
                state_next = S_EMIT;
            end

            S_GOAL:
            begin
                goal_next  = wp_rd;
                state_next = S_POP;
            end

            // take the heap top and the tail entry, or report no path if the heap is empty
            S_POP:
            begin
                if (hcnt_reg == '0)
                begin
                    em_st_next = ST_NOPATH;
                    em_nd_next = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    heap_ra    = '0;
                    heap_rb    = HAW'(hcnt_reg - HCW'(1));
                    hcnt_next  = hcnt_reg - HCW'(1);
                    state_next = S_POPD;
                end
            end

            S_POPD:
            begin
                cur_next   = heap_rda[NODE_W-1:0];
                key_next   = heap_rdb;
                idx_next   = '0;
                state_next = S_SDRD;
            end

            S_SDRD:
            begin
                heap_ra    = HAW'(ca);
                heap_rb    = HAW'(cb);
                state_next = S_SDCMP;
            end

            // one level of sift-down
            S_SDCMP:
            begin
                if (ca >= hcnt_x || child >= key_reg)
                begin
                    if (hcnt_reg != '0)
                    begin
                        heap_we = 1'b1;
                        heap_wa = HAW'(idx_reg);
                        heap_wd = key_reg;
                    end
                    state_next = S_EXP;
                end
                else
                begin
                    heap_we    = 1'b1;
                    heap_wa    = HAW'(idx_reg);
                    heap_wd    = child;
                    idx_next   = use_b ? cb : ca;
                    state_next = S_SDRD;
                end
            end

            S_EXP:
            begin
                if (NCMP'(cur_reg) >= NCMP'(NODES))
                    state_next = S_POP;
                else if (cur_reg == tg_reg)
                begin
                    wc_next    = tg_reg;
                    pn_next    = '0;
                    state_next = S_WPUT;
                end
                else
                begin
                    deg_ra     = NAW'(cur_reg);
                    best_ra    = NAW'(cur_reg);
                    state_next = S_EXD;
                end
            end

            S_EXD:
            begin
                if (!degv_reg[NAW'(cur_reg)])
                    deg_next = '0;
                else if (32'(deg_rd) > MAX_DEGREE)
                    deg_next = DEG_W'(MAX_DEGREE);
                else
                    deg_next = deg_rd;
                bc_next    = best_rd;
                e_next     = '0;
                state_next = S_ECHK;
            end

            S_ECHK:
            begin
                if (e_reg == deg_reg)
                    state_next = S_POP;
                else
                begin
                    edge_ra    = EAW'(32'(cur_reg) * MAX_DEGREE + 32'(e_reg));
                    state_next = S_ETGT;
                end
            end

            S_ETGT:
            begin
                nx_next = edge_rd[EW-1:LEN_W];
                nc_next = nc_calc;
                if (NCMP'(edge_rd[EW-1:LEN_W]) >= NCMP'(NODES))
                begin
                    e_next     = e_reg + DEG_W'(1);
                    state_next = S_ECHK;
                end
                else
                begin
                    best_ra    = NAW'(edge_rd[EW-1:LEN_W]);
                    state_next = S_EBC;
                end
            end

            // relax the neighbour
            S_EBC:
            begin
                if (!known_reg[NAW'(nx_reg)] || nc_reg < best_rd)
                begin
                    best_we = 1'b1;
                    best_wa = NAW'(nx_reg);
                    best_wd = nc_reg;
                    known_next[NAW'(nx_reg)] = 1'b1;
                    wp_ra      = NAW'(nx_reg);
                    state_next = S_DRD;
                end
                else
                begin
                    e_next     = e_reg + DEG_W'(1);
                    state_next = S_ECHK;
                end
            end

            S_DRD:
            begin
                mag_next[0] = abs_diff(wp_rd[3*COORD_W-1:2*COORD_W],
                                       goal_reg[3*COORD_W-1:2*COORD_W]);
                mag_next[1] = abs_diff(wp_rd[2*COORD_W-1:COORD_W],
                                       goal_reg[2*COORD_W-1:COORD_W]);
                mag_next[2] = abs_diff(wp_rd[COORD_W-1:0], goal_reg[COORD_W-1:0]);
                k_next      = '0;
                acc_next    = '0;
                state_next  = S_DMUL;
            end

            // square and accumulate one axis per cycle
            S_DMUL:
            begin
                prod_next = msel * msel;
                if (k_reg != 2'd0)
                    acc_next = acc_reg + SQ_W'(prod_reg);
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    sqn_next   = acc_reg + SQ_W'(prod_reg);
                    sqr_next   = '0;
                    sqb_next   = SQ_W'(1) << (2 * (SQ_ITER - 1));
                    sqc_next   = '0;
                    state_next = S_SQRT;
                end
            end

            // one root bit per cycle
            S_SQRT:
            begin
                if (sqn_reg >= sq_t)
                    sqn_next = sqn_reg - sq_t;
                sqr_next = r_new;
                sqb_next = sqb_reg >> 2;
                sqc_next = sqc_reg + SQC_W'(1);
                if (sqc_reg == SQC_W'(SQ_ITER - 1))
                begin
                    key_next   = {sat_add(nc_reg, COST_W'(r_new)), nx_reg};
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                if (32'(hcnt_reg) >= HEAP_DEPTH)
                begin
                    em_st_next = ST_OVERFLOW;
                    em_nd_next = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = CIW'(hcnt_reg);
                    hcnt_next  = hcnt_reg + HCW'(1);
                    state_next = S_UCHK;
                end
            end

            S_UCHK:
            begin
                if (idx_reg == '0)
                begin
                    heap_we = 1'b1;
                    heap_wa = '0;
                    heap_wd = key_reg;
                    par_we  = 1'b1;
                    par_wa  = NAW'(nx_reg);
                    e_next  = e_reg + DEG_W'(1);
                    state_next = S_ECHK;
                end
                else
                begin
                    heap_ra    = HAW'(par_i);
                    state_next = S_UCMP;
                end
            end

            // one level of sift-up
            S_UCMP:
            begin
                heap_we = 1'b1;
                heap_wa = HAW'(idx_reg);
                if (heap_rda <= key_reg)
                begin
                    heap_wd = key_reg;
                    par_we  = 1'b1;
                    par_wa  = NAW'(nx_reg);
                    e_next  = e_reg + DEG_W'(1);
                    state_next = S_ECHK;
                end
                else
                begin
                    heap_wd    = heap_rda;
                    idx_next   = par_i;
                    state_next = S_UCHK;
                end
            end

            // walk parent links from the target back to the start
            S_WPUT:
            begin
                path_we = 1'b1;
                path_wa = NAW'(pn_reg);
                path_wd = wc_reg;
                pn_next = pn_reg + NCW'(1);
                if (wc_reg == nd_reg || 32'(pn_reg) + 1 >= NODES)
                begin
                    oi_next    = pn_reg;
                    state_next = S_ORD;
                end
                else
                begin
                    par_ra     = NAW'(wc_reg);
                    state_next = S_WNXT;
                end
            end

            S_WNXT:
            begin
                wc_next = par_rd;
                if (NCMP'(par_rd) >= NCMP'(NODES))
                begin
                    oi_next    = pn_reg - NCW'(1);
                    state_next = S_ORD;
                end
                else
                    state_next = S_WPUT;
            end

            S_ORD:
            begin
                path_ra    = NAW'(oi_reg);
                state_next = S_OND;
            end

            S_OND:
            begin
                wc_next    = path_rd;
                best_ra    = NAW'(path_rd);
                state_next = S_OEMIT;
            end

            // emit path nodes, start first; keep the cost read while stalled
            S_OEMIT:
            begin
                best_ra = NAW'(wc_reg);
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_st   = ST_PATH;
                    emit_nd   = wc_reg;
                    emit_cost = best_rd;
                    emit_last = (oi_reg == '0);
                    if (oi_reg == '0)
                        state_next = S_IDLE;
                    else
                    begin
                        oi_next    = oi_reg - NCW'(1);
                        state_next = S_ORD;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hcnt_reg  <= '0;
            known_reg <= '0;
            degv_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hcnt_reg  <= hcnt_next;
            known_reg <= known_next;
            degv_reg  <= degv_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        nd_reg    <= nd_next;
        tg_reg    <= tg_next;
        nb_reg    <= nb_next;
        len_reg   <= len_next;
        cw_reg    <= cw_next;
        goal_reg  <= goal_next;
        idx_reg   <= idx_next;
        key_reg   <= key_next;
        cur_reg   <= cur_next;
        deg_reg   <= deg_next;
        e_reg     <= e_next;
        bc_reg    <= bc_next;
        nc_reg    <= nc_next;
        nx_reg    <= nx_next;
        mag_reg   <= mag_next;
        k_reg     <= k_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        sqn_reg   <= sqn_next;
        sqr_reg   <= sqr_next;
        sqb_reg   <= sqb_next;
        sqc_reg   <= sqc_next;
        pn_reg    <= pn_next;
        oi_reg    <= oi_next;
        wc_reg    <= wc_next;
        em_st_reg <= em_st_next;
        em_nd_reg <= em_nd_next;
        if (emit)
        begin
            ost_reg   <= emit_st;
            ond_reg   <= emit_nd;
            ocost_reg <= emit_cost;
            olast_reg <= emit_last;
        end
    end

endmodule
